>>> hdl/cce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_pkg: shared types, text constants and byte generation functions
// Holds the run descriptor that travels from the decoder to the emitter
// and the functions that produce one HTML byte of a run by position.
// ----------------------------------------------------------------------------
package cce_pkg;

   typedef enum logic [2:0] {
      KIND_CHAR,
      KIND_LT,
      KIND_GT,
      KIND_AMP,
      KIND_QUOT,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_SWAP
   } kind_type;

   typedef enum logic [2:0] {
      COLOR_NONE,
      COLOR_RED,
      COLOR_GREEN,
      COLOR_YELLOW,
      COLOR_BLUE,
      COLOR_PURPLE,
      COLOR_CYAN,
      COLOR_WHITE
   } color_type;

   typedef struct packed {
      kind_type  kind;
      color_type color;
      logic [7:0] chr;
   } run_type;

   localparam int IDX_W = 5;

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_ARM   = 8'h01;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_LF    = 8'h0a;
   localparam logic [7:0] BYTE_LT    = 8'h3c;
   localparam logic [7:0] BYTE_GT    = 8'h3e;
   localparam logic [7:0] BYTE_AMP   = 8'h26;
   localparam logic [7:0] BYTE_QUOT  = 8'h22;

   localparam int HEAD_LEN  = 13;
   localparam int OPEN_LEN  = 20;
   localparam int CLOSE_LEN = 7;

   localparam logic [8*4-1:0]        TXT_LT    = "&lt;";
   localparam logic [8*4-1:0]        TXT_GT    = "&gt;";
   localparam logic [8*5-1:0]        TXT_AMP   = "&amp;";
   localparam logic [8*6-1:0]        TXT_QUOT  = "&quot;";
   localparam logic [8*HEAD_LEN-1:0] TXT_HEAD  = "<font color=#";
   localparam logic [8*CLOSE_LEN-1:0] TXT_CLOSE = "</font>";

   function automatic logic [23:0] color_rgb(color_type c);
      logic [23:0] rgb;
      case (c)
         COLOR_RED:    rgb = 24'hff0000;
         COLOR_GREEN:  rgb = 24'h00ff00;
         COLOR_YELLOW: rgb = 24'hffff00;
         COLOR_BLUE:   rgb = 24'h0000ff;
         COLOR_PURPLE: rgb = 24'hff00ff;
         COLOR_CYAN:   rgb = 24'h00ffff;
         COLOR_WHITE:  rgb = 24'hffffff;
         default:      rgb = 24'h000000;
      endcase
      return rgb;
   endfunction

   function automatic color_type select_color(logic [7:0] b);
      color_type c;
      case (b)
         8'h61:   c = COLOR_NONE;
         8'h72:   c = COLOR_RED;
         8'h67:   c = COLOR_GREEN;
         8'h79:   c = COLOR_YELLOW;
         8'h62:   c = COLOR_BLUE;
         8'h70:   c = COLOR_PURPLE;
         8'h63:   c = COLOR_CYAN;
         8'h77:   c = COLOR_WHITE;
         default: c = COLOR_GREEN;
      endcase
      return c;
   endfunction

   function automatic logic [IDX_W-1:0] run_length(kind_type k);
      logic [IDX_W-1:0] n;
      case (k)
         KIND_CHAR:  n = IDX_W'(1);
         KIND_LT:    n = IDX_W'(4);
         KIND_GT:    n = IDX_W'(4);
         KIND_AMP:   n = IDX_W'(5);
         KIND_QUOT:  n = IDX_W'(6);
         KIND_OPEN:  n = IDX_W'(OPEN_LEN);
         KIND_CLOSE: n = IDX_W'(CLOSE_LEN);
         KIND_SWAP:  n = IDX_W'(OPEN_LEN + CLOSE_LEN);
         default:    n = IDX_W'(1);
      endcase
      return n;
   endfunction

   function automatic logic [7:0] hex_digit(logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = 8'h30 + {4'h0, nib};
      end else begin
         d = 8'h57 + {4'h0, nib};
      end
      return d;
   endfunction

   function automatic logic [7:0] open_byte(color_type c, int p);
      logic [7:0]  b;
      logic [23:0] rgb;
      rgb = color_rgb(c);
      if (p < HEAD_LEN) begin
         b = TXT_HEAD[8*(HEAD_LEN-1-p) +: 8];
      end else if (p < OPEN_LEN - 1) begin
         b = hex_digit(rgb[4*(OPEN_LEN-2-p) +: 4]);
      end else begin
         b = BYTE_GT;
      end
      return b;
   endfunction

   function automatic logic [7:0] run_byte(run_type r, logic [IDX_W-1:0] idx);
      logic [7:0] b;
      int         p;
      p = int'(idx);
      b = 8'h00;
      if (idx < run_length(r.kind)) begin
         case (r.kind)
            KIND_CHAR:  b = r.chr;
            KIND_LT:    b = TXT_LT[8*(3-p) +: 8];
            KIND_GT:    b = TXT_GT[8*(3-p) +: 8];
            KIND_AMP:   b = TXT_AMP[8*(4-p) +: 8];
            KIND_QUOT:  b = TXT_QUOT[8*(5-p) +: 8];
            KIND_OPEN:  b = open_byte(r.color, p);
            KIND_CLOSE: b = TXT_CLOSE[8*(CLOSE_LEN-1-p) +: 8];
            KIND_SWAP: begin
               if (p < CLOSE_LEN) begin
                  b = TXT_CLOSE[8*(CLOSE_LEN-1-p) +: 8];
               end else begin
                  b = open_byte(r.color, p - CLOSE_LEN);
               end
            end
            default:    b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

>>> hdl/cce_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_decode: input byte classifier and color state
// Turns each accepted byte into a run descriptor and keeps the armed flag
// and the current color.
// ----------------------------------------------------------------------------
module cce_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   output logic              run_valid,
   output cce_pkg::run_type  run
);
   import cce_pkg::*;

   logic      await_ff, await_in;
   color_type color_ff, color_in;
   color_type next_color;

   always_comb begin
      next_color = select_color(in_byte);
      await_in   = await_ff;
      color_in   = color_ff;
      run_valid  = 1'b0;
      run.kind   = KIND_CHAR;
      run.color  = next_color;
      run.chr    = in_byte;
      if (await_ff) begin
         await_in = 1'b0;
         color_in = next_color;
         if (next_color != color_ff) begin
            run_valid = 1'b1;
            if (color_ff == COLOR_NONE) begin
               run.kind = KIND_OPEN;
            end else if (next_color == COLOR_NONE) begin
               run.kind = KIND_CLOSE;
            end else begin
               run.kind = KIND_SWAP;
            end
         end
      end else begin
         case (in_byte)
            BYTE_ARM:  await_in = 1'b1;
            BYTE_NUL:  run_valid = 1'b0;
            BYTE_CR: begin
               run_valid = 1'b1;
               run.chr   = BYTE_LF;
            end
            BYTE_LT: begin
               run_valid = 1'b1;
               run.kind  = KIND_LT;
            end
            BYTE_GT: begin
               run_valid = 1'b1;
               run.kind  = KIND_GT;
            end
            BYTE_AMP: begin
               run_valid = 1'b1;
               run.kind  = KIND_AMP;
            end
            BYTE_QUOT: begin
               run_valid = 1'b1;
               run.kind  = KIND_QUOT;
            end
            default:   run_valid = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff <= 1'b0;
         color_ff <= COLOR_NONE;
      end else if (accept) begin
         await_ff <= await_in;
         color_ff <= color_in;
      end
   end

endmodule

>>> hdl/cce_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_emit: run register, byte counter and output register
// Steps through the bytes of one run into the output register, one per
// cycle unless stalled, and takes the next run as the last byte goes out.
// ----------------------------------------------------------------------------
module cce_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  cce_pkg::run_type  run,
   output logic              can_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run
);
   import cce_pkg::*;

   logic             busy_ff, busy_in;
   run_type          run_ff, run_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             out_free, on_last;

   assign out_free = !valid_ff || !rsp_stall;
   assign on_last  = idx_ff == run_length(run_ff.kind) - IDX_W'(1);
   assign can_take = !busy_ff || (out_free && on_last);

   always_comb begin
      busy_in  = busy_ff;
      run_in   = run_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (busy_ff && out_free) begin
         valid_in = 1'b1;
         byte_in  = run_byte(run_ff, idx_ff);
         last_in  = on_last;
         idx_in   = idx_ff + IDX_W'(1);
         if (on_last) begin
            busy_in = 1'b0;
         end
      end else if (out_free) begin
         valid_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         run_in  = run;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      run_ff  <= run_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> hdl/color_code_html_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_code_html_escaper: text to HTML byte stream converter
// Escapes HTML special characters and turns color codes into font tags.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one text byte per transaction. The rsp_ channel
// returns the HTML bytes that the byte causes, one per transaction, with
// rsp_last_of_run set on the final byte of each run. Arming bytes, NUL
// bytes and selectors that keep the color cause no transaction at all.
// An accepted transaction loads its run into the run register of the
// emitter, whose bytes then move one per cycle into the output register
// while the receiver does not stall. Runs are 1 to 27 bytes long; a new
// input transaction is taken in the cycle in which the last byte of the
// current run moves into the output register, so plain characters flow
// at one per cycle without a stall and a longer run holds the input until
// its last byte moves. When the receiver raises rsp_stall, the output
// register holds its byte, the emitter holds its place and req_stall rises
// while a run is in progress. Synchronous reset clears the color state to
// no color, disarms the selector and drops any run in progress.
// ----------------------------------------------------------------------------
module color_code_html_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);
   import cce_pkg::*;

   logic    accept;
   logic    can_take;
   logic    run_valid;
   run_type run;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;

   cce_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .run_valid (run_valid),
      .run       (run)
   );

   cce_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (accept && run_valid),
      .run             (run),
      .can_take        (can_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
